>>> hw/rtl/rsi_pkg.sv
`default_nettype none

package rsi_pkg;

   // default datapath format, signed Q(DATA_WIDTH-FRAC_BITS).FRAC_BITS
   localparam int DATA_WIDTH_DEF = 32;
   localparam int FRAC_BITS_DEF  = 16;

   // control register port
   localparam int CSR_WIDTH       = 32;
   localparam int CSR_INDEX_WIDTH = 1;

   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      CSR_REG_WEIGHT = 1'b0,
      CSR_EPSILON    = 1'b1
   } csr_index_type;

endpackage

`default_nettype wire

>>> hw/rtl/rsi_req_if.sv
`default_nettype none

interface rsi_req_if #(
   parameter int DATA_WIDTH = rsi_pkg::DATA_WIDTH_DEF
);
   logic                         valid;
   logic                         ready;
   logic signed [DATA_WIDTH-1:0] kernel_re;
   logic signed [DATA_WIDTH-1:0] kernel_im;
   logic signed [DATA_WIDTH-1:0] first_reg_re;
   logic signed [DATA_WIDTH-1:0] first_reg_im;
   logic signed [DATA_WIDTH-1:0] second_reg_re;
   logic signed [DATA_WIDTH-1:0] second_reg_im;

   modport source (
      output valid, kernel_re, kernel_im, first_reg_re, first_reg_im,
             second_reg_re, second_reg_im,
      input  ready
   );

   modport sink (
      input  valid, kernel_re, kernel_im, first_reg_re, first_reg_im,
             second_reg_re, second_reg_im,
      output ready
   );
endinterface

`default_nettype wire

>>> hw/rtl/rsi_rsp_if.sv
`default_nettype none

interface rsi_rsp_if #(
   parameter int DATA_WIDTH = rsi_pkg::DATA_WIDTH_DEF
);
   logic                         valid;
   logic                         ready;
   logic signed [DATA_WIDTH-1:0] inv_re;
   logic signed [DATA_WIDTH-1:0] inv_im;
   logic                         saturated;
   logic                         zero_denominator;

   modport source (
      output valid, inv_re, inv_im, saturated, zero_denominator,
      input  ready
   );

   modport sink (
      input  valid, inv_re, inv_im, saturated, zero_denominator,
      output ready
   );
endinterface

`default_nettype wire

>>> hw/rtl/regularized_spectral_inverse_unit.sv
`default_nettype none

// channel   dir  handshake          word
// req_chan  in   valid/ready        kernel, first and second regularizer (re, im)
// rsp_chan  out  valid/ready        inv_re, inv_im, saturated, zero_denominator
// csr_*     in   csr_write_en       csr_index, csr_data
//
// one word enters per cycle while the output register is empty or taken; the restoring
// divider resolves one quotient bit per stage (re and im in parallel).
// synchronous reset clears the valid bits and both control registers.
// all stages advance together while the output register is empty or taken;
// a stall freezes the whole pipe, nothing is dropped or repeated.

module regularized_spectral_inverse_unit #(
   parameter int DATA_WIDTH = rsi_pkg::DATA_WIDTH_DEF,
   parameter int FRAC_BITS  = rsi_pkg::FRAC_BITS_DEF
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   rsi_req_if.sink                                  req_chan,
   rsi_rsp_if.source                                rsp_chan,
   input  wire logic                                csr_write_en,
   input  wire logic [rsi_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  wire logic [rsi_pkg::CSR_WIDTH-1:0]       csr_data
);
   import rsi_pkg::*;

   localparam int DW     = DATA_WIDTH;
   localparam int FB     = FRAC_BITS;
   localparam int CW     = CSR_WIDTH;
   localparam int LO_W   = (DW + 1) / 2;
   localparam int HI_W   = DW - LO_W;
   localparam int SQ_W   = 2 * DW;
   localparam int KK_W   = SQ_W + 1;
   localparam int EN_W   = SQ_W + 2;
   localparam int E_CH   = (EN_W + CW - 1) / CW;
   localparam int EN_PAD = E_CH * CW;
   localparam int WP_W   = EN_W + CW;
   localparam int WT_W   = WP_W - FB;
   localparam int EP_W   = CW + FB;
   localparam int M1_W   = (KK_W > WT_W) ? KK_W : WT_W;
   localparam int M2_W   = (M1_W > EP_W) ? M1_W : EP_W;
   localparam int DEN_W  = M2_W + 2;
   localparam int NUM_W  = DW + 2 * FB;
   localparam int TOP_W  = NUM_W - DW;

   localparam logic [DW-1:0] MAX_POS = {1'b0, {(DW-1){1'b1}}};
   localparam logic [DW-1:0] MAX_NEG = {1'b1, {(DW-1){1'b0}}};

   typedef struct packed {
      logic [DEN_W-1:0] rem_re;
      logic [DEN_W-1:0] rem_im;
      logic [DW-1:0]    low_re;
      logic [DW-1:0]    low_im;
      logic [DW-1:0]    q_re;
      logic [DW-1:0]    q_im;
      logic [DEN_W-1:0] den;
      logic             neg_re;
      logic             neg_im;
      logic             ovf_re;
      logic             ovf_im;
      logic             zd;
   } div_type;

   // control registers
   logic [CW-1:0] weight_ff;
   logic [CW-1:0] epsilon_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         weight_ff  <= '0;
         epsilon_ff <= '0;
      end else if (csr_write_en) begin
         case (csr_index_type'(csr_index))
            CSR_REG_WEIGHT: weight_ff  <= csr_data;
            CSR_EPSILON:    epsilon_ff <= csr_data;
            default: ;
         endcase
      end
   end

   // pipe advance
   logic rsp_valid_ff;
   logic advance;

   assign advance        = !rsp_valid_ff || rsp_chan.ready;
   assign req_chan.ready = advance;

   // stage 1: magnitudes and signs
   logic [DW-1:0] raw_in [6];
   logic [DW-1:0] mag_in [6];
   logic [DW-1:0] s1_mag_ff [6];
   logic          s1_neg_re_ff, s1_neg_im_ff, s1_valid_ff;

   always_comb begin
      raw_in[0] = req_chan.kernel_re;
      raw_in[1] = req_chan.kernel_im;
      raw_in[2] = req_chan.first_reg_re;
      raw_in[3] = req_chan.first_reg_im;
      raw_in[4] = req_chan.second_reg_re;
      raw_in[5] = req_chan.second_reg_im;
      for (int i = 0; i < 6; i++) begin
         mag_in[i] = raw_in[i][DW-1] ? DW'(~raw_in[i] + 1'b1) : raw_in[i];
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_mag_ff    <= mag_in;
         s1_neg_re_ff <= raw_in[0][DW-1];
         s1_neg_im_ff <= raw_in[1][DW-1];
      end
   end

   // stage 2: half-width partial products of each square
   logic [2*HI_W-1:0]      s2_hh_ff [6];
   logic [HI_W+LO_W-1:0]   s2_hl_ff [6];
   logic [2*LO_W-1:0]      s2_ll_ff [6];
   logic [DW-1:0]          s2_mre_ff, s2_mim_ff;
   logic                   s2_neg_re_ff, s2_neg_im_ff, s2_valid_ff;

   always_ff @(posedge clock) begin
      if (advance) begin
         for (int i = 0; i < 6; i++) begin
            s2_hh_ff[i] <= s1_mag_ff[i][DW-1:LO_W] * s1_mag_ff[i][DW-1:LO_W];
            s2_hl_ff[i] <= s1_mag_ff[i][DW-1:LO_W] * s1_mag_ff[i][LO_W-1:0];
            s2_ll_ff[i] <= s1_mag_ff[i][LO_W-1:0] * s1_mag_ff[i][LO_W-1:0];
         end
         s2_mre_ff    <= s1_mag_ff[0];
         s2_mim_ff    <= s1_mag_ff[1];
         s2_neg_re_ff <= s1_neg_re_ff;
         s2_neg_im_ff <= s1_neg_im_ff;
      end
   end

   // stage 3: assemble the squares
   logic [SQ_W-1:0] s3_sq_ff [6];
   logic [DW-1:0]   s3_mre_ff, s3_mim_ff;
   logic            s3_neg_re_ff, s3_neg_im_ff, s3_valid_ff;

   always_ff @(posedge clock) begin
      if (advance) begin
         for (int i = 0; i < 6; i++) begin
            s3_sq_ff[i] <= (SQ_W'(s2_hh_ff[i]) << (2 * LO_W))
                         + (SQ_W'(s2_hl_ff[i]) << (LO_W + 1))
                         + SQ_W'(s2_ll_ff[i]);
         end
         s3_mre_ff    <= s2_mre_ff;
         s3_mim_ff    <= s2_mim_ff;
         s3_neg_re_ff <= s2_neg_re_ff;
         s3_neg_im_ff <= s2_neg_im_ff;
      end
   end

   // stage 4: kernel power and regularizer energy
   logic [KK_W-1:0] s4_kk_ff;
   logic [EN_W-1:0] s4_en_ff;
   logic [DW-1:0]   s4_mre_ff, s4_mim_ff;
   logic            s4_neg_re_ff, s4_neg_im_ff, s4_valid_ff;

   always_ff @(posedge clock) begin
      if (advance) begin
         s4_kk_ff     <= KK_W'(s3_sq_ff[0]) + KK_W'(s3_sq_ff[1]);
         s4_en_ff     <= EN_W'(s3_sq_ff[2]) + EN_W'(s3_sq_ff[3])
                       + EN_W'(s3_sq_ff[4]) + EN_W'(s3_sq_ff[5]);
         s4_mre_ff    <= s3_mre_ff;
         s4_mim_ff    <= s3_mim_ff;
         s4_neg_re_ff <= s3_neg_re_ff;
         s4_neg_im_ff <= s3_neg_im_ff;
      end
   end

   // stage 5: weight times energy, one chunk per multiplier
   logic [EN_PAD-1:0] en_pad;
   logic [2*CW-1:0]   s5_wp_ff [E_CH];
   logic [KK_W-1:0]   s5_kk_ff;
   logic [DW-1:0]     s5_mre_ff, s5_mim_ff;
   logic              s5_neg_re_ff, s5_neg_im_ff, s5_valid_ff;

   assign en_pad = EN_PAD'(s4_en_ff);

   always_ff @(posedge clock) begin
      if (advance) begin
         for (int c = 0; c < E_CH; c++) begin
            s5_wp_ff[c] <= weight_ff * en_pad[c*CW +: CW];
         end
         s5_kk_ff     <= s4_kk_ff;
         s5_mre_ff    <= s4_mre_ff;
         s5_mim_ff    <= s4_mim_ff;
         s5_neg_re_ff <= s4_neg_re_ff;
         s5_neg_im_ff <= s4_neg_im_ff;
      end
   end

   // stage 6: sum the weighted chunks
   logic [WP_W-1:0] wsum_in;
   logic [WP_W-1:0] s6_wsum_ff;
   logic [KK_W-1:0] s6_kk_ff;
   logic [DW-1:0]   s6_mre_ff, s6_mim_ff;
   logic            s6_neg_re_ff, s6_neg_im_ff, s6_valid_ff;

   always_comb begin
      wsum_in = '0;
      for (int c = 0; c < E_CH; c++) begin
         wsum_in = wsum_in + (WP_W'(s5_wp_ff[c]) << (c * CW));
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s6_wsum_ff   <= wsum_in;
         s6_kk_ff     <= s5_kk_ff;
         s6_mre_ff    <= s5_mre_ff;
         s6_mim_ff    <= s5_mim_ff;
         s6_neg_re_ff <= s5_neg_re_ff;
         s6_neg_im_ff <= s5_neg_im_ff;
      end
   end

   // stage 7: denominator
   logic [DEN_W-1:0] s7_den_ff;
   logic [DW-1:0]    s7_mre_ff, s7_mim_ff;
   logic             s7_neg_re_ff, s7_neg_im_ff, s7_valid_ff;

   always_ff @(posedge clock) begin
      if (advance) begin
         s7_den_ff    <= DEN_W'(s6_kk_ff) + (DEN_W'(epsilon_ff) << FB)
                       + DEN_W'(s6_wsum_ff >> FB);
         s7_mre_ff    <= s6_mre_ff;
         s7_mim_ff    <= s6_mim_ff;
         s7_neg_re_ff <= s6_neg_re_ff;
         // conjugate: imaginary numerator is minus kernel_im
         s7_neg_im_ff <= (s6_mim_ff != '0) && !s6_neg_im_ff;
      end
   end

   // divider entry: overflow check on the top numerator bits
   div_type          div_ff [DW+1];
   logic [DW:0]      div_valid_ff;
   div_type          div0_in;
   logic [NUM_W-1:0] num_re, num_im;
   logic [TOP_W-1:0] top_re, top_im;

   always_comb begin
      num_re         = NUM_W'(s7_mre_ff) << (2 * FB);
      num_im         = NUM_W'(s7_mim_ff) << (2 * FB);
      top_re         = num_re[NUM_W-1:DW];
      top_im         = num_im[NUM_W-1:DW];
      div0_in.den    = s7_den_ff;
      div0_in.zd     = (s7_den_ff == '0);
      div0_in.ovf_re = DEN_W'(top_re) >= s7_den_ff;
      div0_in.ovf_im = DEN_W'(top_im) >= s7_den_ff;
      div0_in.rem_re = div0_in.ovf_re ? '0 : DEN_W'(top_re);
      div0_in.rem_im = div0_in.ovf_im ? '0 : DEN_W'(top_im);
      div0_in.low_re = num_re[DW-1:0];
      div0_in.low_im = num_im[DW-1:0];
      div0_in.q_re   = '0;
      div0_in.q_im   = '0;
      div0_in.neg_re = s7_neg_re_ff;
      div0_in.neg_im = s7_neg_im_ff;
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         div_ff[0] <= div0_in;
      end
   end

   // restoring divider, one quotient bit per stage
   for (genvar j = 1; j <= DW; j++) begin : g_div
      logic [DEN_W:0] trial_re, trial_im;
      logic           ge_re, ge_im;
      div_type        div_in;

      always_comb begin
         div_in      = div_ff[j-1];
         trial_re    = {div_ff[j-1].rem_re, div_ff[j-1].low_re[DW-j]};
         trial_im    = {div_ff[j-1].rem_im, div_ff[j-1].low_im[DW-j]};
         ge_re       = trial_re >= {1'b0, div_ff[j-1].den};
         ge_im       = trial_im >= {1'b0, div_ff[j-1].den};
         div_in.rem_re = ge_re ? DEN_W'(trial_re - {1'b0, div_ff[j-1].den})
                               : trial_re[DEN_W-1:0];
         div_in.rem_im = ge_im ? DEN_W'(trial_im - {1'b0, div_ff[j-1].den})
                               : trial_im[DEN_W-1:0];
         div_in.q_re = {div_ff[j-1].q_re[DW-2:0], ge_re};
         div_in.q_im = {div_ff[j-1].q_im[DW-2:0], ge_im};
      end

      always_ff @(posedge clock) begin
         if (advance) begin
            div_ff[j] <= div_in;
         end
      end
   end

   // valid bits for every stage
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         s3_valid_ff  <= 1'b0;
         s4_valid_ff  <= 1'b0;
         s5_valid_ff  <= 1'b0;
         s6_valid_ff  <= 1'b0;
         s7_valid_ff  <= 1'b0;
         div_valid_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff  <= req_chan.valid;
         s2_valid_ff  <= s1_valid_ff;
         s3_valid_ff  <= s2_valid_ff;
         s4_valid_ff  <= s3_valid_ff;
         s5_valid_ff  <= s4_valid_ff;
         s6_valid_ff  <= s5_valid_ff;
         s7_valid_ff  <= s6_valid_ff;
         div_valid_ff <= {div_valid_ff[DW-1:0], s7_valid_ff};
         rsp_valid_ff <= div_valid_ff[DW];
      end
   end

   // saturate, apply sign, zero denominator override
   logic [DW-1:0] lim_re, lim_im, mag_re, mag_im;
   logic          sat_re, sat_im;
   logic [DW-1:0] inv_re_in, inv_im_in;
   logic          sat_in;

   always_comb begin
      lim_re = div_ff[DW].neg_re ? MAX_NEG : MAX_POS;
      lim_im = div_ff[DW].neg_im ? MAX_NEG : MAX_POS;
      sat_re = div_ff[DW].ovf_re || (div_ff[DW].q_re > lim_re);
      sat_im = div_ff[DW].ovf_im || (div_ff[DW].q_im > lim_im);
      mag_re = sat_re ? lim_re : div_ff[DW].q_re;
      mag_im = sat_im ? lim_im : div_ff[DW].q_im;
      if (div_ff[DW].zd) begin
         inv_re_in = '0;
         inv_im_in = '0;
         sat_in    = 1'b0;
      end else begin
         inv_re_in = div_ff[DW].neg_re ? DW'(~mag_re + 1'b1) : mag_re;
         inv_im_in = div_ff[DW].neg_im ? DW'(~mag_im + 1'b1) : mag_im;
         sat_in    = sat_re || sat_im;
      end
   end

   // output register
   logic [DW-1:0] rsp_re_ff, rsp_im_ff;
   logic          rsp_sat_ff, rsp_zd_ff;

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_re_ff  <= inv_re_in;
         rsp_im_ff  <= inv_im_in;
         rsp_sat_ff <= sat_in;
         rsp_zd_ff  <= div_ff[DW].zd;
      end
   end

   assign rsp_chan.valid            = rsp_valid_ff;
   assign rsp_chan.inv_re           = rsp_re_ff;
   assign rsp_chan.inv_im           = rsp_im_ff;
   assign rsp_chan.saturated        = rsp_sat_ff;
   assign rsp_chan.zero_denominator = rsp_zd_ff;

endmodule

`default_nettype wire

>>> verif/rsi_checker.sv
`default_nettype none

module rsi_checker (
   input  wire logic                                clock,
   input  wire logic                                reset,
   rsi_req_if                                       req_mon,
   rsi_rsp_if                                       rsp_mon,
   input  wire logic                                csr_write_en,
   input  wire logic [rsi_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  wire logic [rsi_pkg::CSR_WIDTH-1:0]       csr_data,
   output int                                       fail_count,
   output int                                       pending_count
);
   import rsi_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic signed [31:0] inv_re;
      logic signed [31:0] inv_im;
      logic               saturated;
      logic               zero_denominator;
   } inverse_word_type;

   logic [31:0]      weight_copy;
   logic [31:0]      epsilon_copy;
   inverse_word_type inverse_queue[$];

   // magnitude of a signed 32-bit field, exact for the most negative value
   function automatic logic [31:0] abs32(input logic [31:0] v);
      return v[31] ? (~v + 32'd1) : v;
   endfunction

   // one signed part: mag * 2^32 / denom, truncated, clipped to 32 bits
   function automatic logic [31:0] quotient_part(input logic [31:0] mag, input logic neg,
                                                 input logic [127:0] denom,
                                                 inout logic clip);
      logic [127:0] q;
      logic [127:0] lim;
      q   = ({96'd0, mag} << 32) / denom;
      lim = neg ? 128'h8000_0000 : 128'h7fff_ffff;
      if (q > lim) begin
         q    = lim;
         clip = 1'b1;
      end
      return neg ? (32'd0 - q[31:0]) : q[31:0];
   endfunction

   // regularized inverse conj(K) / (|K|^2 + eps + w*(|R1|^2+|R2|^2))
   function automatic inverse_word_type regularized_inverse(
      input logic [31:0] k_re, k_im, r1_re, r1_im, r2_re, r2_im);
      logic [127:0]     denom;
      logic [127:0]     energy;
      logic [31:0]      m_re, m_im;
      logic             clip;
      inverse_word_type w;
      m_re   = abs32(k_re);
      m_im   = abs32(k_im);
      energy = 128'(abs32(r1_re)) * abs32(r1_re) + 128'(abs32(r1_im)) * abs32(r1_im)
             + 128'(abs32(r2_re)) * abs32(r2_re) + 128'(abs32(r2_im)) * abs32(r2_im);
      denom  = 128'(m_re) * m_re + 128'(m_im) * m_im + (128'(epsilon_copy) << 16)
             + ((128'(weight_copy) * energy) >> 16);
      clip   = 1'b0;
      w      = '0;
      if (denom == 0) begin
         w.zero_denominator = 1'b1;
      end else begin
         w.inv_re    = quotient_part(m_re, k_re[31], denom, clip);
         w.inv_im    = quotient_part(m_im, (m_im != 0) && !k_im[31], denom, clip);
         w.saturated = clip;
      end
      return w;
   endfunction

   // register copy, predict on accepted request, compare on accepted response
   always @(posedge clock) begin
      inverse_word_type exp_w;
      if (reset) begin
         weight_copy   <= '0;
         epsilon_copy  <= '0;
         fail_count    <= 0;
         pending_count <= 0;
         inverse_queue.delete();
      end else begin
         if (csr_write_en) begin
            if (csr_index == CSR_REG_WEIGHT) weight_copy <= csr_data;
            else if (csr_index == CSR_EPSILON) epsilon_copy <= csr_data;
         end
         if (req_mon.valid && req_mon.ready)
            inverse_queue.push_back(regularized_inverse(req_mon.kernel_re, req_mon.kernel_im,
               req_mon.first_reg_re, req_mon.first_reg_im,
               req_mon.second_reg_re, req_mon.second_reg_im));
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (inverse_queue.size() == 0) begin
               $error("response word with no expectation waiting");
               fail_count <= fail_count + 1;
            end else begin
               exp_w = inverse_queue.pop_front();
               if (rsp_mon.inv_re !== exp_w.inv_re ||
                   rsp_mon.inv_im !== exp_w.inv_im ||
                   rsp_mon.saturated !== exp_w.saturated ||
                   rsp_mon.zero_denominator !== exp_w.zero_denominator)
                  fail_count <= fail_count + 1;
               if (rsp_mon.inv_re !== exp_w.inv_re)
                  $error("inv_re expected %0d actual %0d", exp_w.inv_re, rsp_mon.inv_re);
               if (rsp_mon.inv_im !== exp_w.inv_im)
                  $error("inv_im expected %0d actual %0d", exp_w.inv_im, rsp_mon.inv_im);
               if (rsp_mon.saturated !== exp_w.saturated)
                  $error("saturated expected %0b actual %0b",
                         exp_w.saturated, rsp_mon.saturated);
               if (rsp_mon.zero_denominator !== exp_w.zero_denominator)
                  $error("zero_denominator expected %0b actual %0b",
                         exp_w.zero_denominator, rsp_mon.zero_denominator);
            end
         end
         pending_count <= inverse_queue.size();
      end
   end
endmodule

`default_nettype wire

>>> verif/testbench.sv
`default_nettype none

module testbench;
   import rsi_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int IDLE_LIMIT = 3000;

   logic                       clock = 1'b0;
   logic                       reset = 1'b1;
   logic                       csr_write_en = 1'b0;
   logic [CSR_INDEX_WIDTH-1:0] csr_index = CSR_REG_WEIGHT;
   logic [CSR_WIDTH-1:0]       csr_data = '0;
   int                         fail_count;
   int                         pending_count;
   int                         words_sent = 0;
   int                         idle_cycles = 0;
   logic                       hold_done = 1'b0;
   int                         hold_left = 0;

   rsi_req_if req_chan ();
   rsi_rsp_if rsp_chan ();

   regularized_spectral_inverse_unit uut (
      .clock(clock), .reset(reset), .req_chan(req_chan), .rsp_chan(rsp_chan),
      .csr_write_en(csr_write_en), .csr_index(csr_index), .csr_data(csr_data)
   );

   rsi_checker checker_i (
      .clock(clock), .reset(reset), .req_mon(req_chan), .rsp_mon(rsp_chan),
      .csr_write_en(csr_write_en), .csr_index(csr_index), .csr_data(csr_data),
      .fail_count(fail_count), .pending_count(pending_count)
   );

   always #1 clock = ~clock;

   initial begin
      req_chan.valid         = 1'b0;
      req_chan.kernel_re     = '0;
      req_chan.kernel_im     = '0;
      req_chan.first_reg_re  = '0;
      req_chan.first_reg_im  = '0;
      req_chan.second_reg_re = '0;
      req_chan.second_reg_im = '0;
      rsp_chan.ready         = 1'b0;
   end

   // receiver: random stall pattern, plus one long hold-off while words keep coming
   always @(posedge clock) begin
      if (reset) begin
         rsp_chan.ready <= 1'b0;
      end else if (hold_left > 0) begin
         rsp_chan.ready <= 1'b0;
         hold_left      <= hold_left - 1;
      end else if (!hold_done && words_sent >= 700) begin
         hold_done      <= 1'b1;
         hold_left      <= 400;
         rsp_chan.ready <= 1'b0;
      end else if ((words_sent / 150) % 3 == 0) begin
         rsp_chan.ready <= 1'b1;
      end else begin
         rsp_chan.ready <= ($urandom_range(0, 3) != 0);
      end
   end

   // watchdog on cycles with no handshake on either channel
   always @(posedge clock) begin
      if ((req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready) || reset)
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("*** FAILED ***");
         $finish;
      end
   end

   // random field biased toward extremes, small and unit-scale values
   function automatic logic [31:0] pick_field();
      case ($urandom_range(0, 5))
         0, 1:    return $urandom;
         2:       return 32'($signed($urandom_range(0, 2 * 262144)) - 262144);
         3:       return 32'($signed($urandom_range(0, 2 * 131072)) - 65536);
         4: begin
            case ($urandom_range(0, 4))
               0:       return 32'h8000_0000;
               1:       return 32'h7fff_ffff;
               2:       return 32'hffff_ffff;
               3:       return 32'd1;
               default: return 32'h0001_0000;
            endcase
         end
         default: return 32'd0;
      endcase
   endfunction

   task automatic write_csr(input csr_index_type idx, input logic [31:0] value);
      @(posedge clock);
      csr_write_en <= 1'b1;
      csr_index    <= idx;
      csr_data     <= value;
      @(posedge clock);
      csr_write_en <= 1'b0;
   endtask

   task automatic wait_drained();
      @(posedge clock);
      while (pending_count != 0 || (req_chan.valid && req_chan.ready)) @(posedge clock);
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
   endtask

   // drive one word and hold it until taken; valid stays high inside a burst
   task automatic send_word(input logic [31:0] kre, kim, r1re, r1im, r2re, r2im,
                            input bit last_in_burst);
      req_chan.valid         <= 1'b1;
      req_chan.kernel_re     <= kre;
      req_chan.kernel_im     <= kim;
      req_chan.first_reg_re  <= r1re;
      req_chan.first_reg_im  <= r1im;
      req_chan.second_reg_re <= r2re;
      req_chan.second_reg_im <= r2im;
      do @(posedge clock); while (!req_chan.ready);
      words_sent++;
      if (last_in_burst) req_chan.valid <= 1'b0;
   endtask

   // valid drops only where a gap follows, so it is never set and cleared in one step
   task automatic send_random(input int count);
      int burst;
      int gap;
      burst = 0;
      for (int i = 0; i < count; i++) begin
         if (burst == 0) burst = $urandom_range(1, 24);
         burst--;
         gap = 0;
         if (burst == 0 && $urandom_range(0, 2) != 0) gap = $urandom_range(1, 12);
         send_word(pick_field(), pick_field(), pick_field(), pick_field(),
                   pick_field(), pick_field(), gap != 0 || i == count - 1);
         repeat (gap) @(posedge clock);
      end
   endtask

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // plain inverse: zero denominator, tiny and extreme kernels
      send_word(0, 0, 0, 0, 0, 0, 0);
      send_word(0, 0, 32'h7fff_ffff, 32'h8000_0000, 5, 6, 0);
      send_word(1, 0, 0, 0, 0, 0, 0);
      send_word(0, 1, 0, 0, 0, 0, 0);
      send_word(32'h8000_0000, 0, 0, 0, 0, 0, 0);
      send_word(0, 32'h8000_0000, 0, 0, 0, 0, 0);
      send_word(32'h8000_0000, 32'h8000_0000, 0, 0, 0, 0, 0);
      send_word(32'h7fff_ffff, 32'h7fff_ffff, 0, 0, 0, 0, 0);
      send_word(32'h0001_0000, 0, 0, 0, 0, 0, 0);
      send_word(0, 32'h0001_0000, 0, 0, 0, 0, 0);
      send_word(32'hffff_0000, 32'h0001_0000, 0, 0, 0, 0, 0);
      send_word(32'hffff_ffff, 32'hffff_ffff, 0, 0, 0, 0, 1);
      wait_drained();

      // full weight: regularizer extremes, with and without kernel
      write_csr(CSR_REG_WEIGHT, 32'hffff_ffff);
      send_word(0, 0, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 0);
      send_word(0, 0, 1, 0, 0, 0, 0);
      send_word(32'h0001_0000, 0, 32'h0001_0000, 0, 0, 0, 0);
      send_word(32'h0001_0000, 32'h0001_0000, 0, 0, 32'h0001_0000, 32'h7fff_ffff, 0);
      send_word(32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff,
                32'h7fff_ffff, 32'h7fff_ffff, 1);
      wait_drained();

      // weighted and epsilon settings, extremes included
      for (int phase = 0; phase < 6; phase++) begin
         case (phase)
            0: begin write_csr(CSR_REG_WEIGHT, 0); write_csr(CSR_EPSILON, 0); end
            1: write_csr(CSR_EPSILON, 1);
            2: begin write_csr(CSR_REG_WEIGHT, 32'h0001_0000); write_csr(CSR_EPSILON, 0); end
            3: begin write_csr(CSR_REG_WEIGHT, 32'hffff_ffff);
                     write_csr(CSR_EPSILON, 32'hffff_ffff); end
            4: begin write_csr(CSR_REG_WEIGHT, $urandom); write_csr(CSR_EPSILON, $urandom); end
            default: begin write_csr(CSR_REG_WEIGHT, 32'h100); write_csr(CSR_EPSILON, 32'h10); end
         endcase
         send_random(235);
         wait_drained();
      end

      repeat (60) @(posedge clock);
      if (fail_count == 0 && pending_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end
endmodule

`default_nettype wire
